// File: hdl/pfc_pkg.sv
// Package: shared codes, channel map types and the channel map table for the pixel converter.
`default_nettype none

package pfc_pkg;

    // Channel layout codes (source and destination use the same encoding).
    localparam logic [3:0] LAYOUT_ALPHA     = 4'd0;
    localparam logic [3:0] LAYOUT_BGR       = 4'd1;
    localparam logic [3:0] LAYOUT_BGRA      = 4'd2;
    localparam logic [3:0] LAYOUT_LUM       = 4'd3;
    localparam logic [3:0] LAYOUT_LUM_ALPHA = 4'd4;
    localparam logic [3:0] LAYOUT_RED       = 4'd5;
    localparam logic [3:0] LAYOUT_RG        = 4'd6;
    localparam logic [3:0] LAYOUT_RGB       = 4'd7;
    localparam logic [3:0] LAYOUT_RGBA      = 4'd8;

    // Source packing codes.
    localparam logic [1:0] SPACK_BYTE     = 2'd0;
    localparam logic [1:0] SPACK_8888     = 2'd1;
    localparam logic [1:0] SPACK_8888_REV = 2'd2;
    localparam logic [1:0] SPACK_1555_REV = 2'd3;

    // Destination packing codes.
    localparam logic [1:0] DPACK_BYTE = 2'd0;
    localparam logic [1:0] DPACK_565  = 2'd1;
    localparam logic [1:0] DPACK_5551 = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_SOURCE_LAYOUT  = 2'd0;
    localparam logic [1:0] REG_SOURCE_PACKING = 2'd1;
    localparam logic [1:0] REG_DEST_LAYOUT    = 2'd2;
    localparam logic [1:0] REG_DEST_PACKING   = 2'd3;

    // Reciprocal of 31 as a 20-bit fixed-point fraction, exact for dividends below 8192.
    localparam logic [16:0] RECIP31       = 17'd33826;
    localparam int          RECIP31_SHIFT = 20;

    // Full-scale maximum of an unpacked channel value.
    typedef enum logic [1:0] {
        SCALE_1   = 2'd0,
        SCALE_31  = 2'd1,
        SCALE_255 = 2'd2
    } scale_t;

    // Where a channel lives in a layout: present flag and element index.
    typedef struct packed {
        logic       en;
        logic [1:0] idx;
    } chan_key_t;

    // One layout row, entry c for channel c (red, green, blue, alpha).
    typedef chan_key_t [3:0] chan_row_t;

    function automatic chan_key_t ck(input logic en, input logic [1:0] idx);
        chan_key_t k;
        k.en  = en;
        k.idx = idx;
        return k;
    endfunction

    function automatic chan_row_t chan_row(input logic [3:0] layout);
        chan_row_t r;
        case (layout)
            LAYOUT_ALPHA: begin
                r = {ck(1'b1, 2'd0), ck(1'b0, 2'd0), ck(1'b0, 2'd0), ck(1'b0, 2'd0)};
            end
            LAYOUT_BGR: begin
                r = {ck(1'b0, 2'd0), ck(1'b1, 2'd0), ck(1'b1, 2'd1), ck(1'b1, 2'd2)};
            end
            LAYOUT_BGRA: begin
                r = {ck(1'b1, 2'd3), ck(1'b1, 2'd0), ck(1'b1, 2'd1), ck(1'b1, 2'd2)};
            end
            LAYOUT_LUM: begin
                r = {ck(1'b0, 2'd0), ck(1'b1, 2'd0), ck(1'b1, 2'd0), ck(1'b1, 2'd0)};
            end
            LAYOUT_LUM_ALPHA: begin
                r = {ck(1'b1, 2'd1), ck(1'b1, 2'd0), ck(1'b1, 2'd0), ck(1'b1, 2'd0)};
            end
            LAYOUT_RED: begin
                r = {ck(1'b0, 2'd0), ck(1'b0, 2'd0), ck(1'b0, 2'd0), ck(1'b1, 2'd0)};
            end
            LAYOUT_RG: begin
                r = {ck(1'b0, 2'd0), ck(1'b0, 2'd0), ck(1'b1, 2'd1), ck(1'b1, 2'd0)};
            end
            LAYOUT_RGB: begin
                r = {ck(1'b0, 2'd0), ck(1'b1, 2'd2), ck(1'b1, 2'd1), ck(1'b1, 2'd0)};
            end
            LAYOUT_RGBA: begin
                r = {ck(1'b1, 2'd3), ck(1'b1, 2'd2), ck(1'b1, 2'd1), ck(1'b1, 2'd0)};
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/pixel_format_converter.sv
// Top level: three-stage pipelined RGBA pixel format converter with stream ports.
// Path: an accepted item passes through the stage one, stage two and output registers
// before it is presented on the master side.
// Throughput: one item per cycle while the receiver is ready; a stage takes a new item
// when empty or when its successor advances; the three-stage ready chain sets the rate.
// Reset: aresetn is synchronous and active low; it empties all stages and restores the
// configuration to RGBA byte per channel on both sides.
`default_nettype none

module pixel_format_converter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [3:0]  cfg_wdata,
    // Input items.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] pixel_in
    input  wire logic        s_tlast,   // last_in
    // Result items.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] pixel_out
    output logic             m_tuser,   // [0] unsupported
    output logic             m_tlast    // last_out
);

    import pfc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers, decoded directly by stage one. Writes
    // must arrive only while the pipeline is empty; not enforced here.
    // ------------------------------------------------------------------
    logic [3:0] src_layout_reg;
    logic [1:0] src_packing_reg;
    logic [3:0] dst_layout_reg;
    logic [1:0] dst_packing_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_layout_reg  <= LAYOUT_RGBA;
            src_packing_reg <= SPACK_BYTE;
            dst_layout_reg  <= LAYOUT_RGBA;
            dst_packing_reg <= DPACK_BYTE;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SOURCE_LAYOUT:  src_layout_reg  <= cfg_wdata;
                REG_SOURCE_PACKING: src_packing_reg <= cfg_wdata[1:0];
                REG_DEST_LAYOUT:    dst_layout_reg  <= cfg_wdata;
                REG_DEST_PACKING:   dst_packing_reg <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake. A stage loads when it is empty or when its own
    // contents move on in the same cycle.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic ready1, ready2, ready3;

    assign ready3   = !s3_valid_reg || m_tready;
    assign ready2   = !s2_valid_reg || ready3;
    assign ready1   = !s1_valid_reg || ready2;
    assign s_tready = ready1;

    logic load1, load2, load3;
    assign load1 = s_tvalid && ready1;
    assign load2 = s1_valid_reg && ready2;
    assign load3 = s2_valid_reg && ready3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (ready1) s1_valid_reg <= s_tvalid;
            if (ready2) s2_valid_reg <= s1_valid_reg;
            if (ready3) s3_valid_reg <= s2_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage one: unpack the source pixel into four channels, then route
    // them onto four lanes. In byte destination mode lane c carries
    // channel c toward its destination byte. In the packed modes lane k
    // carries the channel that the destination layout puts at slot k,
    // together with the full-scale value of that slot's field.
    // ------------------------------------------------------------------
    logic [7:0] s1_v_next   [4];
    scale_t     s1_m_next   [4];
    logic [7:0] s1_t_next   [4];
    logic       s1_en_next  [4];
    logic [1:0] s1_pos_next [4];
    logic       s1_bad_next;

    logic [7:0] s1_v_reg    [4];
    scale_t     s1_m_reg    [4];
    logic [7:0] s1_t_reg    [4];
    logic       s1_en_reg   [4];
    logic [1:0] s1_pos_reg  [4];
    logic       s1_bad_reg;
    logic [1:0] s1_pack_reg;
    logic       s1_last_reg;

    chan_row_t  row_s, row_d;
    logic [7:0] ch_v [4];
    scale_t     ch_m [4];
    logic [1:0] at   [4];
    logic [3:0] seen;
    logic       pack_bad;
    logic [2:0] nch;
    logic       fast_path;

    always_comb begin
        row_s = chan_row(src_layout_reg);
        row_d = chan_row(dst_layout_reg);

        // Unpack. A missing color reads as zero and a missing alpha as full.
        for (int c = 0; c < 4; c++) begin
            if (!row_s[c].en) begin
                ch_v[c] = (c == 3) ? 8'd1 : 8'd0;
                ch_m[c] = SCALE_1;
            end else begin
                case (src_packing_reg)
                    SPACK_8888: begin
                        ch_v[c] = s_tdata[{~row_s[c].idx, 3'b000} +: 8];
                        ch_m[c] = SCALE_255;
                    end
                    SPACK_1555_REV: begin
                        ch_m[c] = SCALE_31;
                        case (row_s[c].idx)
                            2'd0:    ch_v[c] = {3'b000, s_tdata[4:0]};
                            2'd1:    ch_v[c] = {3'b000, s_tdata[9:5]};
                            2'd2:    ch_v[c] = {3'b000, s_tdata[14:10]};
                            default: begin
                                ch_v[c] = {7'b0000000, s_tdata[15]};
                                ch_m[c] = SCALE_1;
                            end
                        endcase
                    end
                    default: begin
                        ch_v[c] = s_tdata[{row_s[c].idx, 3'b000} +: 8];
                        ch_m[c] = SCALE_255;
                    end
                endcase
            end
        end

        // Slot assignment for the packed destinations: every slot needs a
        // distinct channel, or the combination is unsupported.
        nch      = (dst_packing_reg == DPACK_565) ? 3'd3 : 3'd4;
        seen     = '0;
        pack_bad = 1'b0;
        for (int c = 0; c < 4; c++) begin
            at[c] = 2'd0;
        end
        for (int c = 0; c < 4; c++) begin
            if (3'(c) < nch) begin
                if (!row_d[c].en || {1'b0, row_d[c].idx} >= nch || seen[row_d[c].idx]) begin
                    pack_bad = 1'b1;
                end else begin
                    seen[row_d[c].idx] = 1'b1;
                    at[row_d[c].idx]   = 2'(c);
                end
            end
        end

        // RGBA bytes to BGRA 565 keeps red in the high field.
        fast_path = (src_layout_reg == LAYOUT_RGBA) && (src_packing_reg == SPACK_BYTE) &&
                    (dst_layout_reg == LAYOUT_BGRA) && (dst_packing_reg == DPACK_565);
        if (fast_path) begin
            at[0] = 2'd0;
            at[1] = 2'd1;
            at[2] = 2'd2;
        end

        s1_bad_next = (src_layout_reg > LAYOUT_RGBA) || (dst_layout_reg > LAYOUT_RGBA) ||
                      (dst_packing_reg > DPACK_5551) ||
                      ((dst_packing_reg != DPACK_BYTE) && pack_bad);

        for (int l = 0; l < 4; l++) begin
            if (dst_packing_reg == DPACK_BYTE) begin
                s1_v_next[l]   = ch_v[l];
                s1_m_next[l]   = ch_m[l];
                s1_t_next[l]   = 8'd255;
                s1_en_next[l]  = row_d[l].en;
                s1_pos_next[l] = row_d[l].idx;
            end else begin
                s1_v_next[l]   = ch_v[at[l]];
                s1_m_next[l]   = ch_m[at[l]];
                s1_en_next[l]  = 1'b1;
                s1_pos_next[l] = 2'(l);
                if (dst_packing_reg == DPACK_565) begin
                    s1_t_next[l] = (l == 1) ? 8'd63 : ((l == 3) ? 8'd0 : 8'd31);
                end else begin
                    s1_t_next[l] = (l == 3) ? 8'd1 : 8'd31;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load1) begin
            for (int l = 0; l < 4; l++) begin
                s1_v_reg[l]   <= s1_v_next[l];
                s1_m_reg[l]   <= s1_m_next[l];
                s1_t_reg[l]   <= s1_t_next[l];
                s1_en_reg[l]  <= s1_en_next[l];
                s1_pos_reg[l] <= s1_pos_next[l];
            end
            s1_bad_reg  <= s1_bad_next;
            s1_pack_reg <= dst_packing_reg;
            s1_last_reg <= s_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Stage two: multiply each lane value by its target full scale.
    // ------------------------------------------------------------------
    logic [15:0] s2_prod_reg [4];
    scale_t      s2_m_reg    [4];
    logic        s2_en_reg   [4];
    logic [1:0]  s2_pos_reg  [4];
    logic        s2_bad_reg;
    logic [1:0]  s2_pack_reg;
    logic        s2_last_reg;

    always_ff @(posedge aclk) begin
        if (load2) begin
            for (int l = 0; l < 4; l++) begin
                s2_prod_reg[l] <= 16'(s1_v_reg[l]) * 16'(s1_t_reg[l]);
                s2_m_reg[l]    <= s1_m_reg[l];
                s2_en_reg[l]   <= s1_en_reg[l];
                s2_pos_reg[l]  <= s1_pos_reg[l];
            end
            s2_bad_reg  <= s1_bad_reg;
            s2_pack_reg <= s1_pack_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage three: divide by the source full scale (by 255 through the
    // add-and-shift identity, by 31 through a reciprocal) and pack.
    // ------------------------------------------------------------------
    logic [7:0]  quot [4];
    logic [16:0] sum255 [4];
    logic [29:0] mul31  [4];
    logic [31:0] pix_next;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            sum255[l] = 17'(s2_prod_reg[l]) + 17'(s2_prod_reg[l][15:8]) + 17'd1;
            mul31[l]  = 30'(s2_prod_reg[l][12:0]) * 30'(RECIP31);
            case (s2_m_reg[l])
                SCALE_255: quot[l] = sum255[l][15:8];
                SCALE_31:  quot[l] = mul31[l][RECIP31_SHIFT +: 8];
                default:   quot[l] = s2_prod_reg[l][7:0];
            endcase
        end

        pix_next = '0;
        case (s2_pack_reg)
            DPACK_565: begin
                pix_next[15:0] = {quot[0][4:0], quot[1][5:0], quot[2][4:0]};
            end
            DPACK_5551: begin
                pix_next[15:0] = {quot[3][0], quot[2][4:0], quot[1][4:0], quot[0][4:0]};
            end
            default: begin
                // Later channels win where a layout shares one byte.
                for (int l = 0; l < 4; l++) begin
                    if (s2_en_reg[l]) begin
                        pix_next[{s2_pos_reg[l], 3'b000} +: 8] = quot[l];
                    end
                end
            end
        endcase
        if (s2_bad_reg) begin
            pix_next = '0;
        end
    end

    logic [31:0] out_pix_reg;
    logic        out_bad_reg;
    logic        out_last_reg;

    always_ff @(posedge aclk) begin
        if (load3) begin
            out_pix_reg  <= pix_next;
            out_bad_reg  <= s2_bad_reg;
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = s3_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tuser  = out_bad_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // An unsupported combination always delivers an all-zero pixel.
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 32'd0)
        else $error("unsupported item carries nonzero pixel");

    // Reset empties every stage.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !s1_valid_reg && !s2_valid_reg && !s3_valid_reg)
        else $error("pipeline not empty after reset");

    // A stalled first stage keeps its item.
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !ready2 |=> s1_valid_reg && $stable(s1_v_reg[0]) &&
                                    $stable(s1_last_reg))
        else $error("stage one lost its item during a stall");

    // A stalled second stage keeps its item.
    a_s2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg && !ready3 |=> s2_valid_reg && $stable(s2_prod_reg[0]) &&
                                    $stable(s2_last_reg))
        else $error("stage two lost its item during a stall");
`endif

endmodule

`default_nettype wire

// File: dv/pixel_format_converter_checker.sv
// Checker for the pixel format converter: tracks the format registers, predicts and compares items.
module pixel_format_converter_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pfc_pkg::*;

    typedef struct packed {
        logic [31:0] pixel;
        logic        unsupported;
        logic        last;
    } pixel_result_t;

    pixel_result_t expected_pixels[$];

    logic [3:0] src_layout;
    logic [1:0] src_packing;
    logic [3:0] dst_layout;
    logic [1:0] dst_packing;

    // Element index of red, green, blue, alpha within a layout; -1 where absent.
    function automatic void layout_slots(input logic [3:0] layout, output int pos[4]);
        case (layout)
            LAYOUT_ALPHA:     pos = '{-1, -1, -1, 0};
            LAYOUT_BGR:       pos = '{2, 1, 0, -1};
            LAYOUT_BGRA:      pos = '{2, 1, 0, 3};
            LAYOUT_LUM:       pos = '{0, 0, 0, -1};
            LAYOUT_LUM_ALPHA: pos = '{0, 0, 0, 1};
            LAYOUT_RED:       pos = '{0, -1, -1, -1};
            LAYOUT_RG:        pos = '{0, 1, -1, -1};
            LAYOUT_RGB:       pos = '{0, 1, 2, -1};
            default:          pos = '{0, 1, 2, 3};
        endcase
    endfunction

    function automatic int rescale(input int value, input int full_in, input int full_out);
        return (full_in == 0) ? 0 : (value * full_out) / full_in;
    endfunction

    function automatic pixel_result_t convert_pixel(input logic [31:0] pix, input logic last);
        int            src_pos[4];
        int            dst_pos[4];
        int            val[4];
        int            vmax[4];
        int            at[4];
        int            lanes;
        int            k;
        logic [3:0]    seen;
        logic [31:0]   word;
        pixel_result_t r;
        r.pixel       = '0;
        r.unsupported = 1'b0;
        r.last        = last;
        if (src_layout > LAYOUT_RGBA || dst_layout > LAYOUT_RGBA || dst_packing > DPACK_5551) begin
            r.unsupported = 1'b1;
            return r;
        end
        layout_slots(src_layout, src_pos);
        layout_slots(dst_layout, dst_pos);
        for (int c = 0; c < 4; c++) begin
            k = src_pos[c];
            if (k < 0) begin
                // Missing colors read as zero, missing alpha as full scale.
                val[c]  = (c == 3) ? 1 : 0;
                vmax[c] = 1;
            end else if (src_packing == SPACK_8888) begin
                val[c]  = int'(pix[8*(3-k) +: 8]);
                vmax[c] = 255;
            end else if (src_packing == SPACK_1555_REV) begin
                val[c]  = (k == 3) ? int'(pix[15]) : int'(pix[5*k +: 5]);
                vmax[c] = (k == 3) ? 1 : 31;
            end else begin
                val[c]  = int'(pix[8*k +: 8]);
                vmax[c] = 255;
            end
        end
        word = '0;
        at   = '{0, 0, 0, 0};
        if (src_layout == LAYOUT_RGBA && src_packing == SPACK_BYTE &&
            dst_layout == LAYOUT_BGRA && dst_packing == DPACK_565) begin
            // This pair keeps red in the high bits.
            word = 32'((rescale(val[0], vmax[0], 31) << 11) |
                       (rescale(val[1], vmax[1], 63) << 5) |
                       rescale(val[2], vmax[2], 31));
        end else if (dst_packing == DPACK_BYTE) begin
            for (int c = 0; c < 4; c++) begin
                if (dst_pos[c] >= 0) begin
                    word[8*dst_pos[c] +: 8] = 8'(rescale(val[c], vmax[c], 255));
                end
            end
        end else begin
            lanes = (dst_packing == DPACK_565) ? 3 : 4;
            seen  = '0;
            for (int c = 0; c < lanes; c++) begin
                if (dst_pos[c] < 0 || dst_pos[c] >= lanes || seen[dst_pos[c]]) begin
                    r.unsupported = 1'b1;
                end else begin
                    seen[dst_pos[c]] = 1'b1;
                    at[dst_pos[c]]   = c;
                end
            end
            if (dst_packing == DPACK_565) begin
                word = 32'((rescale(val[at[0]], vmax[at[0]], 31) << 11) |
                           (rescale(val[at[1]], vmax[at[1]], 63) << 5) |
                           rescale(val[at[2]], vmax[at[2]], 31));
            end else begin
                word = 32'(rescale(val[at[0]], vmax[at[0]], 31) |
                           (rescale(val[at[1]], vmax[at[1]], 31) << 5) |
                           (rescale(val[at[2]], vmax[at[2]], 31) << 10) |
                           (rescale(val[at[3]], vmax[at[3]], 1) << 15));
            end
        end
        r.pixel = r.unsupported ? 32'd0 : word;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        pixel_result_t want;
        if (!aresetn) begin
            src_layout  = LAYOUT_RGBA;
            src_packing = SPACK_BYTE;
            dst_layout  = LAYOUT_RGBA;
            dst_packing = DPACK_BYTE;
            mismatches  = 0;
            expected_pixels.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                expected_pixels.push_back(convert_pixel(s_tdata, s_tlast));
            end
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%t: unexpected item: pixel_out %h unsupported %b last_out %b",
                             $time, m_tdata, m_tuser, m_tlast);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_tdata !== want.pixel) begin
                        $display("%t: pixel_out expected %h actual %h",
                                 $time, want.pixel, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser !== want.unsupported) begin
                        $display("%t: unsupported expected %b actual %b",
                                 $time, want.unsupported, m_tuser);
                        mismatches++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%t: last_out expected %b actual %b",
                                 $time, want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            // Registers must change only while the converter is empty; nothing here enforces that.
            if (cfg_we) begin
                case (cfg_index)
                    REG_SOURCE_LAYOUT:  src_layout  = cfg_wdata;
                    REG_SOURCE_PACKING: src_packing = cfg_wdata[1:0];
                    REG_DEST_LAYOUT:    dst_layout  = cfg_wdata;
                    default:            dst_packing = cfg_wdata[1:0];
                endcase
            end
        end
        pending = expected_pixels.size();
    end

endmodule

// File: dv/pixel_format_converter_test.sv
// Testbench top: drives pixels and format settings into the converter and gives the verdict.
module pixel_format_converter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pfc_pkg::*;

    // Codes outside the legal ranges, used to provoke the unsupported flag.
    localparam logic [3:0] LAYOUT_UNDEFINED = 4'hF;
    localparam logic [1:0] DPACK_RESERVED   = 2'd3;

    localparam int PHASES          = 100;
    localparam int ITEMS_PER_PHASE = 20;
    // Phase at which the receiver stops taking items for a long stretch.
    localparam int HOLD_PHASE      = 80;
    localparam int HOLD_CYCLES     = 300;
    // The pipeline is three stages deep; a little margin on top.
    localparam int SETTLE_CYCLES   = 5;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [3:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int mismatches;
    int pending;

    // Percent chance per cycle that the sender or the receiver idles.
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_request;

    pixel_format_converter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    pixel_format_converter_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Overall time limit. A correct run takes a small fraction of this, even with
    // the heaviest receiver stalls and the long hold-off.
    initial begin
        #2ms;
        $display("pixel_format_converter test failed");
        $finish;
    end

    // Receiver: takes items at random according to the current idle rate. When asked,
    // it refuses items without a break for the HOLD_CYCLES hold-off so that the pipeline
    // fills up and the converter has to push back on the sender.
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Waits until every predicted item has come out and the pipeline has settled.
    // Called and returns at a falling edge.
    task automatic wait_idle();
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Writes all four format registers back to back once the converter is empty.
    // The packing words are four bits wide so the unused upper bits get exercised too.
    task automatic set_format(input logic [3:0] src_layout, input logic [3:0] src_packing,
                              input logic [3:0] dst_layout, input logic [3:0] dst_packing);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_SOURCE_LAYOUT;
        cfg_wdata <= src_layout;
        @(negedge aclk);
        cfg_index <= REG_SOURCE_PACKING;
        cfg_wdata <= src_packing;
        @(negedge aclk);
        cfg_index <= REG_DEST_LAYOUT;
        cfg_wdata <= dst_layout;
        @(negedge aclk);
        cfg_index <= REG_DEST_PACKING;
        cfg_wdata <= dst_packing;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Offers one item, possibly after some idle cycles, and returns at the falling edge
    // after it was accepted. Valid stays high between back-to-back items.
    task automatic send_pixel(input logic [31:0] pix, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    initial begin
        logic [31:0] pix;
        logic [3:0]  src_layout;
        logic [3:0]  dst_layout;
        logic [1:0]  dst_packing;

        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_SOURCE_LAYOUT;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part. The reset format is RGBA bytes on both sides, which must pass
        // the pixel straight through.
        send_pixel(32'h0000_0000, 1'b0);
        send_pixel(32'hffff_ffff, 1'b0);
        send_pixel(32'h1234_5678, 1'b1);
        s_tvalid <= 1'b0;

        // RGBA bytes into BGRA 565 keeps red in the high bits rather than swapping.
        set_format(LAYOUT_RGBA, {2'b00, SPACK_BYTE}, LAYOUT_BGRA, {2'b00, DPACK_565});
        send_pixel(32'hffff_ffff, 1'b0);
        send_pixel(32'h8040_2010, 1'b0);
        send_pixel(32'h0000_0000, 1'b1);
        s_tvalid <= 1'b0;

        // 1555 source: five-bit colors and a one-bit alpha widened to bytes; the upper
        // half of the word is ignored.
        set_format(LAYOUT_RGBA, {2'b00, SPACK_1555_REV}, LAYOUT_RGBA, {2'b00, DPACK_BYTE});
        send_pixel(32'h0000_ffff, 1'b0);
        send_pixel(32'hffff_8000, 1'b0);
        send_pixel(32'h0000_7fff, 1'b1);
        s_tvalid <= 1'b0;

        // Reversed byte order in, luminance plus alpha out: the later color channel wins
        // the shared byte and the missing alpha comes out full.
        set_format(LAYOUT_BGR, {2'b11, SPACK_8888}, LAYOUT_LUM_ALPHA, {2'b00, DPACK_BYTE});
        send_pixel(32'ha1b2_c3d4, 1'b1);
        s_tvalid <= 1'b0;

        // Luminance into BGRA 5551.
        set_format(LAYOUT_LUM, {2'b00, SPACK_BYTE}, LAYOUT_BGRA, {2'b00, DPACK_5551});
        send_pixel(32'h0000_00ff, 1'b0);
        send_pixel(32'hffff_ff7f, 1'b1);
        s_tvalid <= 1'b0;

        // Alpha only into RGB 565: all colors come out zero.
        set_format(LAYOUT_ALPHA, {2'b00, SPACK_8888}, LAYOUT_RGB, {2'b01, DPACK_565});
        send_pixel(32'hff00_0000, 1'b0);
        send_pixel(32'h1234_5678, 1'b1);
        s_tvalid <= 1'b0;

        // Red and green only into RGBA 5551: blue zero, alpha full.
        set_format(LAYOUT_RG, {2'b11, SPACK_8888_REV}, LAYOUT_RGBA, {2'b10, DPACK_5551});
        send_pixel(32'h0000_ffff, 1'b1);
        s_tvalid <= 1'b0;

        // Unsupported combinations: a packed destination without distinct color
        // channels, an undefined layout code, and the reserved destination packing.
        set_format(LAYOUT_LUM, {2'b00, SPACK_1555_REV}, LAYOUT_LUM, {2'b00, DPACK_565});
        send_pixel(32'hffff_ffff, 1'b0);
        s_tvalid <= 1'b0;
        set_format(LAYOUT_UNDEFINED, {2'b00, SPACK_BYTE}, LAYOUT_RGBA, {2'b00, DPACK_BYTE});
        send_pixel(32'h5a5a_a5a5, 1'b1);
        s_tvalid <= 1'b0;
        set_format(LAYOUT_RGBA, {2'b00, SPACK_BYTE}, LAYOUT_RGBA, {2'b11, DPACK_RESERVED});
        send_pixel(32'hdead_beef, 1'b1);
        s_tvalid <= 1'b0;

        // Random part: each phase picks a fresh format, mostly legal codes with an
        // occasional undefined layout or the reserved packing, then streams pixels whose
        // bytes lean toward the channel extremes. The first third has a slow receiver,
        // the second a slow sender, the last neither.
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < PHASES / 3) begin
                send_idle_pct = 30;
                recv_idle_pct = 84;
            end else if (phase < 2 * PHASES / 3) begin
                send_idle_pct = 84;
                recv_idle_pct = 30;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            src_layout  = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9))
                                                   : 4'($urandom_range(8));
            dst_layout  = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9))
                                                   : 4'($urandom_range(8));
            dst_packing = ($urandom_range(9) == 0) ? DPACK_RESERVED : 2'($urandom_range(2));
            set_format(src_layout, 4'($urandom_range(15)), dst_layout,
                       {2'($urandom_range(3)), dst_packing});
            if (phase == HOLD_PHASE) begin
                hold_request = 1'b1;
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                for (int b = 0; b < 4; b++) begin
                    case ($urandom_range(3))
                        0:       pix[8*b +: 8] = 8'h00;
                        1:       pix[8*b +: 8] = 8'hff;
                        default: pix[8*b +: 8] = 8'($urandom);
                    endcase
                end
                send_pixel(pix, ($urandom_range(15) == 0) || (i == ITEMS_PER_PHASE - 1));
            end
            s_tvalid <= 1'b0;
        end

        wait_idle();
        repeat (10) @(negedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("pixel_format_converter test passed");
        end else begin
            $display("pixel_format_converter test failed");
        end
        $finish;
    end

endmodule
